>>> hdl/dpt_pkg.sv
// Shared types and constants for the demand paging translator.
// Depends on nothing; every other file in hdl/ imports it.
`default_nettype none

package dpt_pkg;

   // Default sizing handed to the top level parameters.
   localparam int DPT_VA_BITS        = 16;
   localparam int DPT_NUM_FRAMES     = 16;
   localparam int DPT_MIN_PAGE_SHIFT = 8;

   // Fixed architecture constants.
   localparam int MAX_PAGE_SHIFT = 12;
   localparam int ADDR_W         = 16;
   localparam int SHIFT_W        = 5;
   localparam int STAMP_W        = 32;
   localparam int COUNT_W        = 32;
   localparam int VICTIM_W       = 8;
   localparam int FRAME_OUT_W    = 4;
   localparam int SHIFT_CFG_W    = 4;
   localparam int FRAMES_CFG_W   = 5;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 8;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAGE_SHIFT    = 2'd0,
      CSR_FRAMES_IN_USE = 2'd1,
      CSR_REPLACE_MODE  = 2'd2
   } csr_reg_type;

   // Replacement policy codes.
   localparam logic MODE_FIFO = 1'b0;
   localparam logic MODE_LRU  = 1'b1;

   // Register values after reset.
   localparam logic [SHIFT_CFG_W-1:0]  RESET_PAGE_SHIFT    = 4'd12;
   localparam logic [FRAMES_CFG_W-1:0] RESET_FRAMES_IN_USE = 5'd16;
   localparam logic                    RESET_REPLACE_MODE  = MODE_FIFO;

   // Result of the shared age compare unit.
   typedef struct packed {
      logic [STAMP_W-1:0] age;
      logic               older;
   } age_result_type;

endpackage

`default_nettype wire

>>> hdl/dpt_age_unit.sv
// Shared age compare unit used by the frame scan of the paging translator.
// Depends on dpt_pkg for the stamp width and the result struct.
`default_nettype none

module dpt_age_unit import dpt_pkg::*; (
   input  logic [STAMP_W-1:0] now_stamp,
   input  logic [STAMP_W-1:0] frame_stamp,
   input  logic [STAMP_W-1:0] best_age,
   output age_result_type     result
);

   // Age wraps modulo 2^32, so a wrapped access clock keeps the order.
   assign result.age   = now_stamp - frame_stamp;
   assign result.older = result.age > best_age;

endmodule

`default_nettype wire

>>> hdl/demand_paging_translator.sv
// Demand paging translator top level: sequencer, page and frame stores, ring.
// Depends on dpt_pkg and dpt_age_unit.
//
// Each request on the req_ channel carries one virtual address. The block looks
// the page up, maps it on a fault (lowest free frame, else a FIFO or LRU victim)
// and returns one result on the rsp_ channel: physical address, hit, eviction
// details and saturating hit and fault counts. The csr_ channel writes the page
// shift, the frame count and the replacement mode; a write to either of the first
// two flushes every mapping, and it is taken only while idle.
// The time a fault takes is set by the frame scan, which reads one stamp a
// cycle from the stamp memory through the shared age unit, and for LRU by the
// ring compaction pass, which moves one entry a cycle through the single ring memory port.
// The block takes one request at a time; req_ready is high only while idle.
// The result sits in an output register, so the next request is accepted while
// an earlier result still waits; a stalled receiver only holds the block once a
// second result is ready. Reset restores the register defaults, empties all
// mappings and clears the counters and the access clock.
`default_nettype none

module demand_paging_translator import dpt_pkg::*; #(
   parameter int VA_BITS        = DPT_VA_BITS,
   parameter int NUM_FRAMES     = DPT_NUM_FRAMES,
   parameter int MIN_PAGE_SHIFT = DPT_MIN_PAGE_SHIFT
) (
   input  logic                    clock,
   input  logic                    reset,
   // Request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ADDR_W-1:0]       req_virtual_address,
   // Result channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [ADDR_W-1:0]       rsp_physical_address,
   output logic                    rsp_hit,
   output logic                    rsp_evicted,
   output logic [VICTIM_W-1:0]     rsp_victim_page,
   output logic [FRAME_OUT_W-1:0]  rsp_frame_used,
   output logic [COUNT_W-1:0]      rsp_hit_count,
   output logic [COUNT_W-1:0]      rsp_fault_count,
   // Configuration write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int PAGE_BITS  = VA_BITS - MIN_PAGE_SHIFT;
   localparam int PAGE_SLOTS = 1 << PAGE_BITS;
   localparam int FRAME_BITS = $clog2(NUM_FRAMES);
   localparam int NF_W       = $clog2(NUM_FRAMES + 1);
   localparam int CMP_W      = (NF_W > FRAMES_CFG_W) ? NF_W : FRAMES_CFG_W;
   localparam int SH_W       = (PAGE_BITS > ADDR_W) ? PAGE_BITS : ADDR_W;

   localparam logic [ADDR_W-1:0] VA_MASK = (VA_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
                                           ADDR_W'((64'd1 << VA_BITS) - 64'd1);
   localparam logic [FRAME_BITS-1:0] FRAME_LAST = FRAME_BITS'(NUM_FRAMES - 1);

   typedef enum logic [9:0] {
      S_IDLE      = 10'b0000000001,
      S_LOOKUP    = 10'b0000000010,
      S_SCAN      = 10'b0000000100,
      S_SCAN_LAST = 10'b0000001000,
      S_FIFO_GET  = 10'b0000010000,
      S_RM_RUN    = 10'b0000100000,
      S_RM_LAST   = 10'b0001000000,
      S_EVICT     = 10'b0010000000,
      S_MAP       = 10'b0100000000,
      S_RESP      = 10'b1000000000
   } state_type;

   function automatic logic [FRAME_BITS-1:0] ring_next(input logic [FRAME_BITS-1:0] i);
      if (i == FRAME_LAST) return '0;
      return i + 1'b1;
   endfunction

   function automatic logic [FRAME_BITS-1:0] ring_prev(input logic [FRAME_BITS-1:0] i);
      if (i == '0) return FRAME_LAST;
      return i - 1'b1;
   endfunction

   // Control and configuration registers.
   state_type                  state_ff, state_in;
   logic [SHIFT_CFG_W-1:0]     page_shift_ff, page_shift_in;
   logic [FRAMES_CFG_W-1:0]    frames_ff, frames_in;
   logic                       mode_ff, mode_in;
   logic [STAMP_W-1:0]         clock_ff, clock_in;
   logic [COUNT_W-1:0]         hit_total_ff, hit_total_in;
   logic [COUNT_W-1:0]         fault_total_ff, fault_total_in;
   logic [PAGE_SLOTS-1:0]      page_valid_ff, page_valid_in;
   logic [NUM_FRAMES-1:0]      busy_ff, busy_in;
   logic [FRAME_BITS-1:0]      head_ff, head_in;
   logic [FRAME_BITS-1:0]      tail_ff, tail_in;
   logic                       cmp_vld_ff, cmp_vld_in;
   logic                       rm_vld_ff, rm_vld_in;
   logic                       found_ff, found_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // Working registers of the request in flight.
   logic [PAGE_BITS-1:0]       page_ff, page_in;
   logic [ADDR_W-1:0]          offset_ff, offset_in;
   logic [FRAME_BITS-1:0]      frame_ff, frame_in;
   logic [FRAME_BITS-1:0]      scan_idx_ff, scan_idx_in;
   logic [FRAME_BITS-1:0]      idx_d_ff, idx_d_in;
   logic [STAMP_W-1:0]         best_age_ff, best_age_in;
   logic [FRAME_BITS-1:0]      rm_pos_ff, rm_pos_in;
   logic [FRAME_BITS-1:0]      rm_pos_d_ff, rm_pos_d_in;
   logic [FRAME_BITS-1:0]      rm_cnt_ff, rm_cnt_in;
   logic                       hit_ff, hit_in;
   logic                       evicted_ff, evicted_in;
   logic [PAGE_BITS-1:0]       victim_ff, victim_in;

   // Result registers.
   logic [ADDR_W-1:0]          rsp_pa_ff, rsp_pa_in;
   logic                       rsp_hit_ff, rsp_hit_in;
   logic                       rsp_evicted_ff, rsp_evicted_in;
   logic [VICTIM_W-1:0]        rsp_victim_ff, rsp_victim_in;
   logic [FRAME_OUT_W-1:0]     rsp_frame_ff, rsp_frame_in;
   logic [COUNT_W-1:0]         rsp_hits_ff, rsp_hits_in;
   logic [COUNT_W-1:0]         rsp_faults_ff, rsp_faults_in;

   // Memories and their registered read data.
   logic [FRAME_BITS-1:0]      pf_mem    [PAGE_SLOTS];
   logic [PAGE_BITS-1:0]       owner_mem [NUM_FRAMES];
   logic [STAMP_W-1:0]         stamp_mem [NUM_FRAMES];
   logic [FRAME_BITS-1:0]      ring_mem  [NUM_FRAMES];
   logic [FRAME_BITS-1:0]      pf_rd_ff;
   logic [PAGE_BITS-1:0]       owner_rd_ff;
   logic [STAMP_W-1:0]         stamp_rd_ff;
   logic [FRAME_BITS-1:0]      ring_rd_ff;

   logic                       pf_we, owner_we, stamp_we, ring_we;
   logic [FRAME_BITS-1:0]      stamp_waddr, ring_waddr, ring_wdata;
   logic [FRAME_BITS-1:0]      owner_raddr, ring_raddr;

   // Effective configuration and request decode.
   logic [SHIFT_W-1:0]         eff_shift;
   logic [CMP_W-1:0]           frames_ext;
   logic [FRAME_BITS-1:0]      nf_last;
   logic [ADDR_W-1:0]          va_req;
   logic [SH_W-1:0]            va_shifted;
   logic [PAGE_BITS-1:0]       page_req;
   logic [ADDR_W-1:0]          offset_mask;
   age_result_type             age_res;

   dpt_age_unit u_age (
      .now_stamp   (clock_ff),
      .frame_stamp (stamp_rd_ff),
      .best_age    (best_age_ff),
      .result      (age_res)
   );

   // Out-of-range register values are saturated where they are used; the lower
   // bound of the page shift is checked first.
   always_comb begin
      if (SHIFT_W'(page_shift_ff) < SHIFT_W'(MIN_PAGE_SHIFT)) begin
         eff_shift = SHIFT_W'(MIN_PAGE_SHIFT);
      end else if (SHIFT_W'(page_shift_ff) > SHIFT_W'(MAX_PAGE_SHIFT)) begin
         eff_shift = SHIFT_W'(MAX_PAGE_SHIFT);
      end else begin
         eff_shift = SHIFT_W'(page_shift_ff);
      end
   end

   assign frames_ext = CMP_W'(frames_ff);

   always_comb begin
      if (frames_ff == '0) begin
         nf_last = '0;
      end else if (frames_ext > CMP_W'(NUM_FRAMES)) begin
         nf_last = FRAME_LAST;
      end else begin
         nf_last = FRAME_BITS'(frames_ext - 1'b1);
      end
   end

   assign va_req      = req_virtual_address & VA_MASK;
   assign va_shifted  = SH_W'(va_req) >> eff_shift;
   assign page_req    = va_shifted[PAGE_BITS-1:0];
   assign offset_mask = (ADDR_W'(1) << eff_shift) - ADDR_W'(1);

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      page_shift_in  = page_shift_ff;
      frames_in      = frames_ff;
      mode_in        = mode_ff;
      clock_in       = clock_ff;
      hit_total_in   = hit_total_ff;
      fault_total_in = fault_total_ff;
      page_valid_in  = page_valid_ff;
      busy_in        = busy_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      cmp_vld_in     = cmp_vld_ff;
      rm_vld_in      = rm_vld_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff;
      page_in        = page_ff;
      offset_in      = offset_ff;
      frame_in       = frame_ff;
      scan_idx_in    = scan_idx_ff;
      idx_d_in       = idx_d_ff;
      best_age_in    = best_age_ff;
      rm_pos_in      = rm_pos_ff;
      rm_pos_d_in    = rm_pos_d_ff;
      rm_cnt_in      = rm_cnt_ff;
      hit_in         = hit_ff;
      evicted_in     = evicted_ff;
      victim_in      = victim_ff;
      rsp_pa_in      = rsp_pa_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_victim_in  = rsp_victim_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_hits_in    = rsp_hits_ff;
      rsp_faults_in  = rsp_faults_ff;
      pf_we          = 1'b0;
      owner_we       = 1'b0;
      stamp_we       = 1'b0;
      ring_we        = 1'b0;
      stamp_waddr    = frame_ff;
      ring_waddr     = tail_ff;
      ring_wdata     = frame_ff;
      owner_raddr    = frame_ff;
      ring_raddr     = (state_ff == S_RM_RUN) ? rm_pos_ff : head_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               case (csr_index)
                  CSR_PAGE_SHIFT: begin
                     page_shift_in = csr_data[SHIFT_CFG_W-1:0];
                     page_valid_in = '0;
                     busy_in       = '0;
                     head_in       = '0;
                     tail_in       = '0;
                  end
                  CSR_FRAMES_IN_USE: begin
                     frames_in     = csr_data[FRAMES_CFG_W-1:0];
                     page_valid_in = '0;
                     busy_in       = '0;
                     head_in       = '0;
                     tail_in       = '0;
                  end
                  CSR_REPLACE_MODE: begin
                     mode_in = csr_data[0];
                  end
                  default: begin
                  end
               endcase
            end
            if (req_valid) begin
               page_in   = page_req;
               offset_in = va_req & offset_mask;
               clock_in  = clock_ff + 1'b1;
               state_in  = S_LOOKUP;
            end
         end

         S_LOOKUP: begin
            victim_in  = '0;
            evicted_in = 1'b0;
            if (page_valid_ff[page_ff]) begin
               // Hit: refresh the use stamp of the frame that holds the page.
               hit_in      = 1'b1;
               frame_in    = pf_rd_ff;
               stamp_we    = 1'b1;
               stamp_waddr = pf_rd_ff;
               if (hit_total_ff != '1) begin
                  hit_total_in = hit_total_ff + 1'b1;
               end
               state_in = S_RESP;
            end else begin
               hit_in      = 1'b0;
               scan_idx_in = '0;
               cmp_vld_in  = 1'b0;
               if (fault_total_ff != '1) begin
                  fault_total_in = fault_total_ff + 1'b1;
               end
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            // The stamp of the previous frame arrives in the cycle after its index.
            if (cmp_vld_ff && ((idx_d_ff == '0) || age_res.older)) begin
               best_age_in = age_res.age;
               frame_in    = idx_d_ff;
            end
            if (!busy_ff[scan_idx_ff]) begin
               frame_in = scan_idx_ff;
               state_in = S_MAP;
            end else begin
               idx_d_in   = scan_idx_ff;
               cmp_vld_in = 1'b1;
               if (scan_idx_ff == nf_last) begin
                  state_in = S_SCAN_LAST;
               end else begin
                  scan_idx_in = scan_idx_ff + 1'b1;
               end
            end
         end

         S_SCAN_LAST: begin
            if ((idx_d_ff == '0) || age_res.older) begin
               best_age_in = age_res.age;
               frame_in    = idx_d_ff;
            end
            cmp_vld_in = 1'b0;
            evicted_in = 1'b1;
            if (mode_ff == MODE_FIFO) begin
               state_in = S_FIFO_GET;
            end else begin
               rm_pos_in = head_ff;
               rm_cnt_in = '0;
               rm_vld_in = 1'b0;
               found_in  = 1'b0;
               state_in  = S_RM_RUN;
            end
         end

         S_FIFO_GET: begin
            // The oldest loaded frame is at the ring head.
            frame_in    = ring_rd_ff;
            head_in     = ring_next(head_ff);
            owner_raddr = ring_rd_ff;
            state_in    = S_MAP;
         end

         S_RM_RUN: begin
            // Close the gap left by the victim: once it has been seen, each
            // later entry moves back one place.
            if (rm_vld_ff) begin
               if (found_ff) begin
                  ring_we    = 1'b1;
                  ring_waddr = ring_prev(rm_pos_d_ff);
                  ring_wdata = ring_rd_ff;
               end
               if (ring_rd_ff == frame_ff) begin
                  found_in = 1'b1;
               end
            end
            rm_pos_in   = ring_next(rm_pos_ff);
            rm_pos_d_in = rm_pos_ff;
            rm_vld_in   = 1'b1;
            if (rm_cnt_ff == nf_last) begin
               state_in = S_RM_LAST;
            end else begin
               rm_cnt_in = rm_cnt_ff + 1'b1;
            end
         end

         S_RM_LAST: begin
            if (found_ff) begin
               ring_we    = 1'b1;
               ring_waddr = ring_prev(rm_pos_d_ff);
               ring_wdata = ring_rd_ff;
            end
            rm_vld_in = 1'b0;
            state_in  = S_EVICT;
         end

         S_EVICT: begin
            owner_raddr = frame_ff;
            state_in    = S_MAP;
         end

         S_MAP: begin
            if (evicted_ff) begin
               page_valid_in[owner_rd_ff] = 1'b0;
               victim_in = owner_rd_ff;
            end else begin
               victim_in = '0;
            end
            page_valid_in[page_ff] = 1'b1;
            busy_in[frame_ff]      = 1'b1;
            pf_we    = 1'b1;
            owner_we = 1'b1;
            stamp_we = 1'b1;
            ring_we  = 1'b1;
            // After an LRU eviction the ring slot just before the tail is free
            // again; any other fault appends at the tail.
            if (evicted_ff && (mode_ff == MODE_LRU)) begin
               ring_waddr = ring_prev(tail_ff);
            end else begin
               ring_waddr = tail_ff;
               tail_in    = ring_next(tail_ff);
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_pa_in      = (ADDR_W'(frame_ff) << eff_shift) | offset_ff;
               rsp_hit_in     = hit_ff;
               rsp_evicted_in = evicted_ff;
               rsp_victim_in  = VICTIM_W'(victim_ff);
               rsp_frame_in   = FRAME_OUT_W'(frame_ff);
               rsp_hits_in    = hit_total_ff;
               rsp_faults_in  = fault_total_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         page_shift_ff  <= RESET_PAGE_SHIFT;
         frames_ff      <= RESET_FRAMES_IN_USE;
         mode_ff        <= RESET_REPLACE_MODE;
         clock_ff       <= '0;
         hit_total_ff   <= '0;
         fault_total_ff <= '0;
         page_valid_ff  <= '0;
         busy_ff        <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         cmp_vld_ff     <= 1'b0;
         rm_vld_ff      <= 1'b0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         page_shift_ff  <= page_shift_in;
         frames_ff      <= frames_in;
         mode_ff        <= mode_in;
         clock_ff       <= clock_in;
         hit_total_ff   <= hit_total_in;
         fault_total_ff <= fault_total_in;
         page_valid_ff  <= page_valid_in;
         busy_ff        <= busy_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         cmp_vld_ff     <= cmp_vld_in;
         rm_vld_ff      <= rm_vld_in;
         found_ff       <= found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff        <= page_in;
      offset_ff      <= offset_in;
      frame_ff       <= frame_in;
      scan_idx_ff    <= scan_idx_in;
      idx_d_ff       <= idx_d_in;
      best_age_ff    <= best_age_in;
      rm_pos_ff      <= rm_pos_in;
      rm_pos_d_ff    <= rm_pos_d_in;
      rm_cnt_ff      <= rm_cnt_in;
      hit_ff         <= hit_in;
      evicted_ff     <= evicted_in;
      victim_ff      <= victim_in;
      rsp_pa_ff      <= rsp_pa_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_victim_ff  <= rsp_victim_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_hits_ff    <= rsp_hits_in;
      rsp_faults_ff  <= rsp_faults_in;
   end

   // Page table: frame of each resident page, read while a request is accepted.
   always_ff @(posedge clock) begin
      if (pf_we) begin
         pf_mem[page_ff] <= frame_ff;
      end
      pf_rd_ff <= pf_mem[page_req];
   end

   // Owning page of each frame, read to find the victim of an eviction.
   always_ff @(posedge clock) begin
      if (owner_we) begin
         owner_mem[frame_ff] <= page_ff;
      end
      owner_rd_ff <= owner_mem[owner_raddr];
   end

   // Use stamps, read one frame a cycle by the scan.
   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_mem[stamp_waddr] <= clock_ff;
      end
      stamp_rd_ff <= stamp_mem[scan_idx_ff];
   end

   // Load-order ring of frames, oldest at the head.
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      ring_rd_ff <= ring_mem[ring_raddr];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_pa_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_evicted          = rsp_evicted_ff;
   assign rsp_victim_page      = rsp_victim_ff;
   assign rsp_frame_used       = rsp_frame_ff;
   assign rsp_hit_count        = rsp_hits_ff;
   assign rsp_fault_count      = rsp_faults_ff;

endmodule

`default_nettype wire
